>>> src/kmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the KMP pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_LEN_W   = 5;
  localparam int PAT_BYTES   = 16;
  localparam int PAT_IDX_W   = 4;
  localparam int START_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic load;
    logic build_step;
    logic build_finish;
    logic match_step;
    logic emit;
  } kmp_cmd_t;

  typedef struct packed {
    logic table_ready;
    logic build_done;
    logic follow;
    logic out_free;
  } kmp_status_t;

endpackage

>>> src/kmp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_controller
// Sequencer: accepts a word, builds the table if not ready or on a start flag,
// follows failure links, then hands the result to the output register.
// ----------------------------------------------------------------------------
module kmp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 start_flag,
  input  kmp_pkg::kmp_status_t status,
  output kmp_pkg::kmp_cmd_t    cmd
);
  import kmp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_MATCH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (start_flag || !status.table_ready) begin
            state_next = ST_BUILD;
          end else begin
            state_next = ST_MATCH;
          end
        end
      end
      ST_BUILD: begin
        if (status.build_done) begin
          cmd.build_finish = 1'b1;
          state_next       = ST_MATCH;
        end else begin
          cmd.build_step = 1'b1;
        end
      end
      ST_MATCH: begin
        if (status.follow) begin
          cmd.match_step = 1'b1;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == ST_IDLE);
    end
  end

endmodule

>>> src/kmp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_datapath
// Pattern registers, prefix table, build and match indexes, text position
// and the output register.
// ----------------------------------------------------------------------------
module kmp_datapath #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kmp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                      text_char,
  input  logic                            start_flag,
  input  kmp_pkg::kmp_cmd_t               cmd,
  output kmp_pkg::kmp_status_t            status,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic                            match_found,
  output logic [kmp_pkg::START_W-1:0]     match_start
);
  import kmp_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [CFG_DATA_W-1:0]    pattern_low;
  logic [CFG_DATA_W-1:0]    pattern_high;
  logic [CFG_LEN_W-1:0]     pattern_length;
  logic [8*PAT_BYTES-1:0]   pattern;

  logic [IDX_W-1:0]         prefix_table [MAX_PATTERN];
  logic                     table_ready;
  logic [IDX_W-1:0]         matched_length;
  logic [POSITION_BITS-1:0] text_position;

  logic [7:0]               cur_char;
  logic [LEN_W-1:0]         bld_i;
  logic [IDX_W-1:0]         bld_len;
  logic [IDX_W-1:0]         j;

  logic [LEN_W-1:0]         n_eff;
  logic [LEN_W-1:0]         n_new;
  logic [7:0]               pat_i;
  logic [7:0]               pat_len;
  logic [7:0]               pat_j;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         rd_data;
  logic                     follow;
  logic [LEN_W-1:0]         j_adv;
  logic                     found;
  logic [POSITION_BITS-1:0] start_pos;

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    if (len == '0) begin
      r = LEN_W'(1);
    end else if (32'(len) > MAX_PATTERN) begin
      r = LEN_W'(MAX_PATTERN);
    end else begin
      r = LEN_W'(len);
    end
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] p,
                                          input logic [PAT_IDX_W-1:0] k);
    return p[8*k +: 8];
  endfunction

  assign pattern = {pattern_high, pattern_low};
  assign n_eff   = eff_len(pattern_length);
  assign n_new   = (cfg_index == REG_PATTERN_LENGTH) ?
                   eff_len(cfg_data[CFG_LEN_W-1:0]) : n_eff;

  assign pat_i   = pat_byte(pattern, PAT_IDX_W'(bld_i[IDX_W-1:0]));
  assign pat_len = pat_byte(pattern, PAT_IDX_W'(bld_len));
  assign pat_j   = pat_byte(pattern, PAT_IDX_W'(j));

  assign follow  = (j != '0) && (pat_j != cur_char);
  assign j_adv   = LEN_W'(j) + LEN_W'(pat_j == cur_char);
  assign found   = (j_adv == n_eff);
  assign start_pos = text_position - POSITION_BITS'(n_eff) + POSITION_BITS'(1);

  always_comb begin
    if (cmd.build_step) begin
      rd_addr = bld_len - IDX_W'(1);
    end else if (follow) begin
      rd_addr = j - IDX_W'(1);
    end else begin
      rd_addr = IDX_W'(n_eff - LEN_W'(1));
    end
  end

  assign rd_data = prefix_table[rd_addr];

  assign status.table_ready = table_ready;
  assign status.build_done  = (bld_i >= n_eff);
  assign status.follow      = follow;
  assign status.out_free    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prefix_table[0] <= '0;
    end else if (cmd.build_step) begin
      if (pat_i == pat_len) begin
        prefix_table[bld_i[IDX_W-1:0]] <= bld_len + IDX_W'(1);
      end else if (bld_len == '0) begin
        prefix_table[bld_i[IDX_W-1:0]] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_char <= text_char;
      bld_i    <= LEN_W'(1);
      bld_len  <= '0;
      if (start_flag || (LEN_W'(matched_length) >= n_eff)) begin
        j <= '0;
      end else begin
        j <= matched_length;
      end
    end else if (cmd.build_step) begin
      if (pat_i == pat_len) begin
        bld_len <= bld_len + IDX_W'(1);
        bld_i   <= bld_i + LEN_W'(1);
      end else if (bld_len == '0) begin
        bld_i <= bld_i + LEN_W'(1);
      end else begin
        bld_len <= rd_data;
      end
    end else if (cmd.match_step) begin
      j <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= CFG_LEN_W'(1);
      table_ready    <= 1'b0;
      matched_length <= '0;
      text_position  <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we && (cfg_index == REG_PATTERN_LOW || cfg_index == REG_PATTERN_HIGH ||
                     cfg_index == REG_PATTERN_LENGTH)) begin
        case (cfg_index)
          REG_PATTERN_LOW:    pattern_low    <= cfg_data;
          REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
          REG_PATTERN_LENGTH: pattern_length <= cfg_data[CFG_LEN_W-1:0];
          default: ;
        endcase
        table_ready <= 1'b0;
        if (LEN_W'(matched_length) >= n_new) begin
          matched_length <= '0;
        end
      end
      if (cmd.load && start_flag) begin
        text_position  <= '0;
        matched_length <= '0;
        table_ready    <= 1'b0;
      end
      if (cmd.build_finish) begin
        table_ready <= 1'b1;
      end
      if (cmd.emit) begin
        matched_length <= found ? rd_data : j_adv[IDX_W-1:0];
        text_position  <= text_position + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      match_found <= found;
      match_start <= found ? START_W'(start_pos) : '0;
    end
  end

`ifndef SYNTHESIS
  a_ml_below_len: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(matched_length) < n_eff)
    else $error("matched length not below pattern length");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwrites a waiting word");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !match_found) |-> (match_start == '0))
    else $error("match_start nonzero without a match");

  a_build_unready: assert property (@(posedge clk) disable iff (rst)
    cmd.build_step |-> !table_ready)
    else $error("table build while table marked ready");
`endif

endmodule

>>> src/kmp_pattern_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_unit
// Streaming Knuth-Morris-Pratt matcher against one configured pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Write pattern_low (0), pattern_high (1) and pattern_length (2) through
//   cfg_we/cfg_index/cfg_data while the block is idle. Text bytes enter on
//   the s_ stream one word at a time; s_tuser set starts a new text.
//   Every input word yields one output word on the m_ stream.
// Throughput:
//   One word is in work at a time. Each word is loaded, then follows failure
//   links in the match loop until its result can be emitted. A word with the
//   start flag, or the first word after reset or a configuration write, first
//   runs a prefix table build (one compare or table lookup per cycle).
// Reset:
//   rst clears position, match length, pattern (length 1) and output valid;
//   the table is rebuilt on the first word.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   word is accepted meanwhile and its result is held until the slot frees.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_unit #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kmp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] text_char
  input  logic                            s_tuser,  // [0] start_of_text
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,  // [31:0] match_start
  output logic                            m_tuser   // [0] match_found
);
  import kmp_pkg::*;

  kmp_cmd_t    cmd;
  kmp_status_t status;

  kmp_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .start_flag (s_tuser),
    .status     (status),
    .cmd        (cmd)
  );

  kmp_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_char   (s_tdata),
    .start_flag  (s_tuser),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .match_found (m_tuser),
    .match_start (m_tdata)
  );

endmodule
